/* design/pcxrle_pkg.sv */
// Shared types, constants and helpers for the PCX RLE planar decoder.
package pcxrle_pkg;

    localparam int DIM_W  = 13;
    localparam int ADDR_W = 26;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 6;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [16:0]       MAX_DIMENSION = 17'd4096;
    localparam logic [BYTE_W-1:0] RUN_FLAG      = 8'hC0;
    localparam logic [CNT_W-1:0]  COUNT_MASK    = 6'h3F;

    localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;

    // register index, taken from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // where a pixel step takes its value and count from
    typedef enum logic [1:0] {
        SRC_LITERAL,
        SRC_RUNSTART,
        SRC_HELD
    } t_src;

    typedef struct packed {
        logic pixel;
        logic status_item;
        logic load_count;
        logic clear_pos;
    } t_cmd;

    typedef struct packed {
        logic en;
        logic is_flag;
        logic full;
        logic count_zero;
        logic run_done;
    } t_sts;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [APB_DW-1:0] v);
        logic [DIM_W-1:0] low;
        low = v[DIM_W-1:0];
        if ({4'b0, low} > MAX_DIMENSION) begin
            return MAX_DIMENSION[DIM_W-1:0];
        end
        return low;
    endfunction

endpackage

/* design/pcxrle_regs.sv */
// Configuration register file behind the APB-style port.
module pcxrle_regs
    import pcxrle_pkg::*;
#(
    parameter int PLANE_COUNT = 3,
    parameter int SPAN_W      = DIM_W + $clog2(PLANE_COUNT + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [DIM_W-1:0]  o_width,
    output logic [DIM_W-1:0]  o_height,
    output logic [SPAN_W-1:0] o_span
);

    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic [SPAN_W-1:0] r_span;
    logic [DIM_W-1:0]  wdata_clamped;
    logic              reg_idx;
    logic              wr_en;

    assign reg_idx       = paddr[2];
    assign wr_en         = psel && penable && pwrite;
    assign wdata_clamped = clamp_dim(pwdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_span   <= SPAN_W'(WIDTH_RST) * SPAN_W'(PLANE_COUNT);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_WIDTH: begin
                    r_width <= wdata_clamped;
                    // row pitch of all planes, kept ready for the address multiply
                    r_span  <= SPAN_W'(wdata_clamped) * SPAN_W'(PLANE_COUNT);
                end
                REG_HEIGHT: begin
                    r_height <= wdata_clamped;
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = {{(APB_DW-DIM_W){1'b0}}, r_width};
            REG_HEIGHT: prdata = {{(APB_DW-DIM_W){1'b0}}, r_height};
        endcase
    end

    assign pready   = 1'b1;
    assign o_width  = r_width;
    assign o_height = r_height;
    assign o_span   = r_span;

endmodule

/* design/pcxrle_ctrl.sv */
// Byte-level control state machine of the PCX RLE decoder.
module pcxrle_ctrl
    import pcxrle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_final_byte,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_src o_src,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_BYTE,
        ST_VALUE,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_last;
    logic   n_last;
    logic   accept;

    assign o_in_ready = i_sts.en && (r_state != ST_EMIT);
    assign accept     = i_in_valid && o_in_ready;

    // pixel source follows the state alone, so the run status never loops back into it
    always_comb begin
        unique case (r_state)
            ST_VALUE: o_src = SRC_RUNSTART;
            ST_EMIT:  o_src = SRC_HELD;
            default:  o_src = SRC_LITERAL;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        o_cmd   = '{pixel: 1'b0, status_item: 1'b0, load_count: 1'b0, clear_pos: 1'b0};
        unique case (r_state)
            ST_BYTE: begin
                if (accept) begin
                    if (i_sts.full) begin
                        o_cmd.clear_pos = i_final_byte;
                    end else if (i_sts.is_flag) begin
                        if (i_final_byte) begin
                            // stream cut right after a run flag
                            o_cmd.status_item = 1'b1;
                            o_cmd.clear_pos   = 1'b1;
                        end else begin
                            o_cmd.load_count = 1'b1;
                            n_state          = ST_VALUE;
                        end
                    end else begin
                        o_cmd.pixel = 1'b1;
                        if (i_sts.run_done) begin
                            o_cmd.clear_pos = i_final_byte;
                        end else begin
                            n_state = ST_EMIT;
                            n_last  = i_final_byte;
                        end
                    end
                end
            end
            ST_VALUE: begin
                if (accept) begin
                    n_state = ST_BYTE;
                    if (i_sts.full || i_sts.count_zero) begin
                        o_cmd.clear_pos = i_final_byte;
                    end else begin
                        o_cmd.pixel = 1'b1;
                        if (i_sts.run_done) begin
                            o_cmd.clear_pos = i_final_byte;
                        end else begin
                            n_state = ST_EMIT;
                            n_last  = i_final_byte;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (i_sts.en) begin
                    o_cmd.pixel = 1'b1;
                    if (i_sts.run_done) begin
                        o_cmd.clear_pos = r_last;
                        n_state         = ST_BYTE;
                    end
                end
            end
            default: begin
                n_state = ST_BYTE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_BYTE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

endmodule

/* design/pcxrle_dpath.sv */
// Position counters, pixel generator and address pipeline of the decoder.
module pcxrle_dpath
    import pcxrle_pkg::*;
#(
    parameter int PLANE_COUNT = 3,
    parameter int PL_W        = $clog2(PLANE_COUNT + 1),
    parameter int SPAN_W      = DIM_W + PL_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [DIM_W-1:0]  i_width,
    input  logic [DIM_W-1:0]  i_height,
    input  logic [SPAN_W-1:0] i_span,
    input  logic [BYTE_W-1:0] i_stream_byte,
    input  t_cmd              i_cmd,
    input  t_src              i_src,
    output t_sts              o_sts,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [ADDR_W-1:0] o_pixel_address,
    output logic [BYTE_W-1:0] o_pixel_value,
    output logic              o_write_valid,
    output logic              o_status,
    output logic              o_run_end
);

    localparam int PROD_W = DIM_W + SPAN_W;
    localparam int POFF_W = PL_W + DIM_W;

    typedef struct packed {
        logic [DIM_W-1:0] col;
        logic [PL_W-1:0]  plane;
        logic [DIM_W-1:0] row;
    } t_pos;

    // wrap a full line onto the next plane, a full plane set onto the next row
    function automatic t_pos wrap_pos(input t_pos p, input logic [DIM_W-1:0] w);
        t_pos q;
        q = p;
        if (q.col >= w) begin
            q.col   = '0;
            q.plane = q.plane + 1'b1;
        end
        if (q.plane >= PL_W'(PLANE_COUNT)) begin
            q.plane = '0;
            q.row   = q.row + 1'b1;
        end
        return q;
    endfunction

    t_pos              r_pos;
    t_pos              n_pos;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_remain;
    logic [BYTE_W-1:0] r_value;

    t_pos              w_cur;
    t_pos              w_step;
    t_pos              w_nxt;
    logic [BYTE_W-1:0] val;
    logic [CNT_W-1:0]  cnt;
    logic              drop;
    logic              more;
    logic              next_drop;
    logic              run_end;
    logic              issue;
    logic              en;

    // stage 1: generated item
    logic              r_s1_vld;
    t_pos              r_s1_pos;
    logic [BYTE_W-1:0] r_s1_val;
    logic              r_s1_wv;
    logic              r_s1_st;
    logic              r_s1_end;
    // stage 2: partial products
    logic              r_s2_vld;
    logic [ADDR_W-1:0] r_s2_rowoff;
    logic [POFF_W-1:0] r_s2_planeoff;
    logic [DIM_W-1:0]  r_s2_col;
    logic [BYTE_W-1:0] r_s2_val;
    logic              r_s2_wv;
    logic              r_s2_st;
    logic              r_s2_end;
    // output register
    logic              r_out_vld;
    logic [ADDR_W-1:0] r_out_addr;
    logic [BYTE_W-1:0] r_out_val;
    logic              r_out_wv;
    logic              r_out_st;
    logic              r_out_end;

    logic [PROD_W-1:0] row_prod;
    logic [POFF_W-1:0] plane_prod;

    assign en = !r_out_vld || i_out_ready;

    always_comb begin
        val = (i_src == SRC_HELD) ? r_value : i_stream_byte;
        unique case (i_src)
            SRC_LITERAL:  cnt = CNT_W'(1);
            SRC_RUNSTART: cnt = r_count;
            SRC_HELD:     cnt = r_remain;
            default:      cnt = '0;
        endcase
    end

    always_comb begin
        w_cur      = wrap_pos(r_pos, i_width);
        drop       = (w_cur.row >= i_height);
        w_step     = w_cur;
        w_step.col = w_cur.col + 1'b1;
        // look one pixel ahead so the last write of a cut-off run carries run_end
        w_nxt      = wrap_pos(w_step, i_width);
        next_drop  = (w_nxt.row >= i_height);
        more       = (cnt > CNT_W'(1));
        run_end    = !more || next_drop;
    end

    assign issue = (i_cmd.pixel && !drop) || i_cmd.status_item;

    always_comb begin
        n_pos = r_pos;
        if (i_cmd.pixel) begin
            if (drop) begin
                n_pos = w_cur;
            end else if (more && next_drop) begin
                n_pos = w_nxt;
            end else begin
                n_pos = w_step;
            end
        end
        if (i_cmd.clear_pos) begin
            n_pos = '0;
        end
    end

    always_comb begin
        o_sts.en         = en;
        o_sts.is_flag    = ((i_stream_byte & RUN_FLAG) == RUN_FLAG);
        o_sts.full       = (r_pos.row >= i_height);
        o_sts.count_zero = (r_count == '0);
        o_sts.run_done   = drop || run_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= '0;
        end else begin
            r_pos <= n_pos;
            if (i_cmd.load_count) begin
                r_count <= i_stream_byte[CNT_W-1:0] & COUNT_MASK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pixel && !drop && !run_end) begin
            r_value  <= val;
            r_remain <= cnt - 1'b1;
        end
    end

    assign row_prod   = PROD_W'(r_s1_pos.row) * PROD_W'(i_span);
    assign plane_prod = POFF_W'(r_s1_pos.plane) * POFF_W'(i_width);

    // whole pipeline advances together; a held output freezes every stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld  <= issue;
            r_s2_vld  <= r_s1_vld;
            r_out_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (i_cmd.status_item) begin
                r_s1_pos <= '0;
                r_s1_val <= '0;
                r_s1_wv  <= 1'b0;
                r_s1_st  <= 1'b1;
                r_s1_end <= 1'b1;
            end else begin
                r_s1_pos <= w_cur;
                r_s1_val <= val;
                r_s1_wv  <= 1'b1;
                r_s1_st  <= 1'b0;
                r_s1_end <= run_end;
            end
            r_s2_rowoff   <= row_prod[ADDR_W-1:0];
            r_s2_planeoff <= plane_prod;
            r_s2_col      <= r_s1_pos.col;
            r_s2_val      <= r_s1_val;
            r_s2_wv       <= r_s1_wv;
            r_s2_st       <= r_s1_st;
            r_s2_end      <= r_s1_end;
            r_out_addr    <= r_s2_rowoff + ADDR_W'(r_s2_planeoff) + ADDR_W'(r_s2_col);
            r_out_val     <= r_s2_val;
            r_out_wv      <= r_s2_wv;
            r_out_st      <= r_s2_st;
            r_out_end     <= r_s2_end;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_pixel_address = r_out_addr;
    assign o_pixel_value   = r_out_val;
    assign o_write_valid   = r_out_wv;
    assign o_status        = r_out_st;
    assign o_run_end       = r_out_end;

endmodule

/* design/pcx_rle_planar_decoder.sv */
// Each result passes the stage 1, stage 2 and output registers after the transfer of the
// byte that causes it. Literal bytes are taken one per cycle while the output is not
// stalled; a value byte gives a run of up to n pixels, one per unstalled cycle, with no new
// input byte taken until the run ends. A stalled output freezes the address pipeline and
// holds off input transfers. Reset (synchronous, active low) clears position, run state and
// pipeline valids; width and height return to 640 and 480. No clearing pass is needed.
module pcx_rle_planar_decoder
    import pcxrle_pkg::*;
#(
    parameter int PLANE_COUNT = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BYTE_W-1:0] i_stream_byte,
    input  logic              i_final_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [ADDR_W-1:0] o_pixel_address,
    output logic [BYTE_W-1:0] o_pixel_value,
    output logic              o_write_valid,
    output logic              o_status,
    output logic              o_run_end,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int PL_W   = $clog2(PLANE_COUNT + 1);
    localparam int SPAN_W = DIM_W + PL_W;

    logic [DIM_W-1:0]  cfg_width;
    logic [DIM_W-1:0]  cfg_height;
    logic [SPAN_W-1:0] cfg_span;
    t_cmd              cmd;
    t_src              src;
    t_sts              sts;

    pcxrle_regs #(
        .PLANE_COUNT (PLANE_COUNT),
        .SPAN_W      (SPAN_W)
    ) u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_width  (cfg_width),
        .o_height (cfg_height),
        .o_span   (cfg_span)
    );

    pcxrle_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_final_byte (i_final_byte),
        .i_sts        (sts),
        .o_in_ready   (o_in_ready),
        .o_src        (src),
        .o_cmd        (cmd)
    );

    pcxrle_dpath #(
        .PLANE_COUNT (PLANE_COUNT),
        .PL_W        (PL_W),
        .SPAN_W      (SPAN_W)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_width         (cfg_width),
        .i_height        (cfg_height),
        .i_span          (cfg_span),
        .i_stream_byte   (i_stream_byte),
        .i_cmd           (cmd),
        .i_src           (src),
        .o_sts           (sts),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_pixel_address (o_pixel_address),
        .o_pixel_value   (o_pixel_value),
        .o_write_valid   (o_write_valid),
        .o_status        (o_status),
        .o_run_end       (o_run_end)
    );

    // a held result blocks new input transfers
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while output stalled");

    // each result is either a pixel write or a status report
    a_write_xor_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_write_valid != o_status))
        else $error("result neither or both write and status");

    // truncation status is always a lone, zeroed, closing result
    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |->
            o_run_end && (o_pixel_address == '0) && (o_pixel_value == '0))
        else $error("malformed status result");

endmodule
